FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the face normal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define TFN_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TFN_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/tfn_pkg.sv
// Package with the shared constants, types and helpers of the face normal block.
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned NormFracDef   = 14;

  // Edges are scaled so that their largest magnitude has its top bit here.
  localparam int unsigned EdgeTop   = 30;
  // The cross product is scaled so that its largest magnitude has its top bit here.
  localparam int unsigned CrossTop  = 29;
  localparam int unsigned CrossMagW = CrossTop + 1;
  localparam int unsigned SqSumW    = 2 * CrossMagW + 2;
  localparam int unsigned RootW     = CrossMagW + 1;

  typedef struct packed {
    logic                          degen;
    logic [2:0]                    neg;
    logic [2:0][CrossMagW-1:0]     mag;
  } cross_t;

  // Position of the highest set bit, zero for a zero word.
  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

FILE: rtl/core/tfn_in_if.sv
// Input channel carrying the three triangle points.
`timescale 1ns / 1ps
interface tfn_in_if #(parameter int unsigned W = tfn_pkg::CoordWidthDef);
  logic         valid;
  logic         ready;
  logic [W-1:0] base_x, base_y, base_z;
  logic [W-1:0] first_x, first_y, first_z;
  logic [W-1:0] second_x, second_y, second_z;

  modport source(output valid, base_x, base_y, base_z, first_x, first_y, first_z,
                 second_x, second_y, second_z, input ready);
  modport sink(input valid, base_x, base_y, base_z, first_x, first_y, first_z,
               second_x, second_y, second_z, output ready);
endinterface

FILE: rtl/core/tfn_out_if.sv
// Output channel carrying the unit normal and the degenerate flag.
`timescale 1ns / 1ps
interface tfn_out_if #(parameter int unsigned W = tfn_pkg::NormFracDef + 2);
  logic         valid;
  logic         ready;
  logic [W-1:0] normal_x, normal_y, normal_z;
  logic         degenerate;

  modport source(output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

FILE: rtl/core/tfn_norm.sv
// Normalization pipeline: sum of squares, square root and per-component division.
`timescale 1ns / 1ps
module tfn_norm #(
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NormFracDef
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     vld_i,
  input  tfn_pkg::cross_t                          cross_i,
  output logic                                     vld_o,
  output logic                                     degen_o,
  output logic [2:0][NORMAL_FRAC_BITS+1:0]         normal_o
);
  import tfn_pkg::*;

  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned NW  = F + 2;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned DW  = RootW + F;
  localparam int unsigned DST = F + 1;

  // Squares and sum.
  logic                        sqr_vld_q;
  cross_t                      sqr_c_q;
  logic [2:0][2*CrossMagW-1:0] sqr_q;

  logic [RootW:0]              rt_vld_q;
  cross_t                      rt_c_q    [RootW+1];
  logic [SqSumW-1:0]           rt_rem_q  [RootW+1];
  logic [RootW-1:0]            rt_root_q [RootW+1];

  logic [DST:0]                dv_vld_q;
  logic [2:0]                  dv_neg_q   [DST+1];
  logic                        dv_degen_q [DST+1];
  logic [RootW-1:0]            dv_len_q   [DST+1];
  logic [2:0][DW-1:0]          dv_rem_q   [DST+1];
  logic [2:0][QW-1:0]          dv_quo_q   [DST+1];

  logic                        out_vld_q;
  logic                        out_degen_q;
  logic [2:0][NW-1:0]          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqr_vld_q   <= 1'b0;
      rt_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      sqr_vld_q   <= vld_i;
      rt_vld_q[0] <= sqr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqr_c_q <= cross_i;
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= (2*CrossMagW)'(cross_i.mag[i]) * (2*CrossMagW)'(cross_i.mag[i]);
      end
      rt_c_q[0]    <= sqr_c_q;
      rt_rem_q[0]  <= SqSumW'(sqr_q[0]) + SqSumW'(sqr_q[1]) + SqSumW'(sqr_q[2]);
      rt_root_q[0] <= '0;
    end
  end

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < RootW; k++) begin : g_root
    localparam int unsigned I = RootW - 1 - k;
    logic [63:0] trial;
    logic        ge;

    always_comb begin
      trial = (64'(rt_root_q[k]) << (I + 1)) + (64'd1 << (2 * I));
      ge    = 64'(rt_rem_q[k]) >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        rt_vld_q[k+1] <= rt_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_c_q[k+1]    <= rt_c_q[k];
        rt_rem_q[k+1]  <= ge ? rt_rem_q[k] - trial[SqSumW-1:0] : rt_rem_q[k];
        rt_root_q[k+1] <= ge ? rt_root_q[k] | (RootW'(1) << I) : rt_root_q[k];
      end
    end
  end

  // Dividends get half the length added, so the quotient rounds to nearest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= rt_vld_q[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_neg_q[0]   <= rt_c_q[RootW].neg;
      dv_degen_q[0] <= rt_c_q[RootW].degen;
      dv_len_q[0]   <= rt_root_q[RootW];
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= (DW'(rt_c_q[RootW].mag[i]) << F) + DW'(rt_root_q[RootW] >> 1);
      end
      dv_quo_q[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage for all three components.
  for (genvar t = 0; t < DST; t++) begin : g_div
    localparam int unsigned J = F - t;
    logic [DW-1:0] dvs;

    assign dvs = DW'(dv_len_q[t]) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[t+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[t+1] <= dv_vld_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_neg_q[t+1]   <= dv_neg_q[t];
        dv_degen_q[t+1] <= dv_degen_q[t];
        dv_len_q[t+1]   <= dv_len_q[t];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_q[t][i] >= dvs) begin
            dv_rem_q[t+1][i] <= dv_rem_q[t][i] - dvs;
            dv_quo_q[t+1][i] <= dv_quo_q[t][i] | (QW'(1) << J);
          end else begin
            dv_rem_q[t+1][i] <= dv_rem_q[t][i];
            dv_quo_q[t+1][i] <= dv_quo_q[t][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= dv_vld_q[DST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_degen_q <= dv_degen_q[DST];
      for (int i = 0; i < 3; i++) begin
        if (dv_degen_q[DST]) begin
          out_q[i] <= '0;
        end else if (dv_neg_q[DST][i]) begin
          out_q[i] <= NW'(0) - {1'b0, dv_quo_q[DST][i]};
        end else begin
          out_q[i] <= {1'b0, dv_quo_q[DST][i]};
        end
      end
    end
  end

  assign vld_o    = out_vld_q;
  assign degen_o  = out_degen_q;
  assign normal_o = out_q;

endmodule

FILE: rtl/core/triangle_face_normal_top.sv
// Top level of the triangle face normal pipeline.
// Usage:
//   in_i carries one triangle per item: base, first and second point, each
//   coordinate signed Q16.16 of COORD_WIDTH bits. out_o returns one item per
//   input item: the unit normal of (first - base) x (second - base) in signed
//   Q1.NORMAL_FRAC_BITS and a degenerate flag, set with a zero normal when an
//   edge has zero length or the edges are parallel.
//   The pipeline includes 31 square root stages and NORMAL_FRAC_BITS + 1
//   division stages, all of them in tfn_norm.
//   Throughput is one item per cycle; items are independent of each other.
//   The whole pipeline advances together: when the output holds an item that
//   the receiver does not take, every stage and in_i.ready stall until it is
//   taken, so nothing is dropped or repeated.
//   Reset clears all stage valid bits; the pipeline comes up empty and ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module triangle_face_normal_top #(
  parameter int unsigned COORD_WIDTH      = tfn_pkg::CoordWidthDef,
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NormFracDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  tfn_in_if.sink    in_i,
  tfn_out_if.source out_o
);
  import tfn_pkg::*;

  localparam int unsigned EW  = COORD_WIDTH + 1;
  localparam int unsigned ESW = EW + EdgeTop;
  localparam int unsigned CSW = 63 + CrossTop;
  localparam int unsigned NW  = NORMAL_FRAC_BITS + 2;

  logic              en;
  logic [8:0]        vld_q;

  logic [2:0][EW-1:0] ea_q, ec_q;
  logic [2:0][EW-1:0] am_q, cm_q;
  logic [2:0]         an_q, cn_q;
  logic [2:0][EW-1:0] am3_q, cm3_q;
  logic [2:0]         an3_q, cn3_q;
  logic [5:0]         apos_q, cpos_q;
  logic               ezero_q;
  logic signed [31:0] sa_q [3];
  logic signed [31:0] sc_q [3];
  logic               degen4_q, degen5_q, degen6_q, degen7_q, degen8_q;
  logic signed [63:0] prod_q [6];
  logic signed [63:0] cr_q [3];
  logic [2:0][62:0]   crm_q, crm8_q;
  logic [2:0]         crn_q, crn8_q;
  logic [5:0]         crpos_q;
  cross_t             cross_q;

  logic                out_vld;
  logic                out_degen;
  logic [2:0][NW-1:0]  out_normal;

  assign en         = !out_vld || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:0], in_i.valid};
    end
  end

  // Edge differences, then magnitudes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ea_q[0] <= {in_i.first_x[COORD_WIDTH-1], in_i.first_x}
               - {in_i.base_x[COORD_WIDTH-1], in_i.base_x};
      ea_q[1] <= {in_i.first_y[COORD_WIDTH-1], in_i.first_y}
               - {in_i.base_y[COORD_WIDTH-1], in_i.base_y};
      ea_q[2] <= {in_i.first_z[COORD_WIDTH-1], in_i.first_z}
               - {in_i.base_z[COORD_WIDTH-1], in_i.base_z};
      ec_q[0] <= {in_i.second_x[COORD_WIDTH-1], in_i.second_x}
               - {in_i.base_x[COORD_WIDTH-1], in_i.base_x};
      ec_q[1] <= {in_i.second_y[COORD_WIDTH-1], in_i.second_y}
               - {in_i.base_y[COORD_WIDTH-1], in_i.base_y};
      ec_q[2] <= {in_i.second_z[COORD_WIDTH-1], in_i.second_z}
               - {in_i.base_z[COORD_WIDTH-1], in_i.base_z};
      for (int i = 0; i < 3; i++) begin
        an_q[i] <= ea_q[i][EW-1];
        cn_q[i] <= ec_q[i][EW-1];
        am_q[i] <= ea_q[i][EW-1] ? EW'(0) - ea_q[i] : ea_q[i];
        cm_q[i] <= ec_q[i][EW-1] ? EW'(0) - ec_q[i] : ec_q[i];
      end
    end
  end

  // Leading one of the largest magnitude of each edge.
  logic [EW-1:0] amax, cmax;
  always_comb begin
    amax = am_q[0];
    if (am_q[1] > amax) amax = am_q[1];
    if (am_q[2] > amax) amax = am_q[2];
    cmax = cm_q[0];
    if (cm_q[1] > cmax) cmax = cm_q[1];
    if (cm_q[2] > cmax) cmax = cm_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      am3_q   <= am_q;
      cm3_q   <= cm_q;
      an3_q   <= an_q;
      cn3_q   <= cn_q;
      apos_q  <= msb_pos(64'(amax));
      cpos_q  <= msb_pos(64'(cmax));
      ezero_q <= (amax == '0) || (cmax == '0);
    end
  end

  // Shifting left by the target and right by the leading one position
  // truncates toward zero exactly like a plain right shift would.
  logic [ESW-1:0] ash [3];
  logic [ESW-1:0] csh [3];
  logic [31:0]    aval [3];
  logic [31:0]    cval [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ash[i]  = ({{EdgeTop{1'b0}}, am3_q[i]} << EdgeTop) >> apos_q;
      csh[i]  = ({{EdgeTop{1'b0}}, cm3_q[i]} << EdgeTop) >> cpos_q;
      aval[i] = {1'b0, ash[i][EdgeTop:0]};
      cval[i] = {1'b0, csh[i][EdgeTop:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sa_q[i] <= an3_q[i] ? $signed(32'd0 - aval[i]) : $signed(aval[i]);
        sc_q[i] <= cn3_q[i] ? $signed(32'd0 - cval[i]) : $signed(cval[i]);
      end
      degen4_q <= ezero_q;

      prod_q[0] <= sa_q[1] * sc_q[2];
      prod_q[1] <= sa_q[2] * sc_q[1];
      prod_q[2] <= sa_q[2] * sc_q[0];
      prod_q[3] <= sa_q[0] * sc_q[2];
      prod_q[4] <= sa_q[0] * sc_q[1];
      prod_q[5] <= sa_q[1] * sc_q[0];
      degen5_q  <= degen4_q;

      cr_q[0]  <= prod_q[0] - prod_q[1];
      cr_q[1]  <= prod_q[2] - prod_q[3];
      cr_q[2]  <= prod_q[4] - prod_q[5];
      degen6_q <= degen5_q;

      for (int i = 0; i < 3; i++) begin
        crn_q[i] <= cr_q[i][63];
        crm_q[i] <= cr_q[i][63] ? 63'(64'd0 - cr_q[i]) : cr_q[i][62:0];
      end
      degen7_q <= degen6_q;
    end
  end

  logic [62:0] crmax;
  always_comb begin
    crmax = crm_q[0];
    if (crm_q[1] > crmax) crmax = crm_q[1];
    if (crm_q[2] > crmax) crmax = crm_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crm8_q   <= crm_q;
      crn8_q   <= crn_q;
      crpos_q  <= msb_pos(64'(crmax));
      degen8_q <= degen7_q || (crmax == '0);
    end
  end

  logic [CSW-1:0] crsh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crsh[i] = ({{CrossTop{1'b0}}, crm8_q[i]} << CrossTop) >> crpos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cross_q.degen <= degen8_q;
      cross_q.neg   <= crn8_q;
      for (int i = 0; i < 3; i++) begin
        cross_q.mag[i] <= crsh[i][CrossMagW-1:0];
      end
    end
  end

  tfn_norm #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_tfn_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld_q[8]),
    .cross_i (cross_q),
    .vld_o   (out_vld),
    .degen_o (out_degen),
    .normal_o(out_normal)
  );

  assign out_o.valid      = out_vld;
  assign out_o.degenerate = out_degen;
  assign out_o.normal_x   = out_normal[0];
  assign out_o.normal_y   = out_normal[1];
  assign out_o.normal_z   = out_normal[2];

  localparam logic signed [NW-1:0] OneLim = NW'(1) << NORMAL_FRAC_BITS;
  logic norm_in_range;
  assign norm_in_range =
      ($signed(out_normal[0]) <= OneLim) && ($signed(out_normal[0]) >= -OneLim) &&
      ($signed(out_normal[1]) <= OneLim) && ($signed(out_normal[1]) >= -OneLim) &&
      ($signed(out_normal[2]) <= OneLim) && ($signed(out_normal[2]) >= -OneLim);

  `TFN_ASSERT(a_degen_zero, out_vld && out_degen |-> out_normal == '0, "degenerate normal not zero")
  `TFN_ASSERT(a_norm_range, out_vld |-> norm_in_range, "normal component beyond unit range")
  `TFN_ASSERT(a_stall_hold, !en |=> $stable(vld_q), "pipeline moved during a stall")
  `TFN_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_o.valid, "output valid during reset")

endmodule

FILE: verif/tfn_normal_checker.sv
// Checker that predicts the unit normal of every accepted triangle and compares results.
`timescale 1ns / 1ps
module tfn_normal_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfn_in_if.sink      tri_mon,
  tfn_out_if.sink     norm_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_t;

  normal_t normals_due[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = normals_due.size();

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Brings the largest magnitude into [2^top, 2^(top+1)); returns 0 for a zero vector.
  function automatic bit shift_to_top(inout logic signed [63:0] v[3], input int top);
    logic [63:0] m[3];
    logic [63:0] big;
    logic [63:0] s;
    int rsh;
    int lsh;
    big = 0;
    rsh = 0;
    lsh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) return 0;
    while ((big >> rsh) >= (64'd1 << (top + 1))) rsh++;
    while ((big << lsh) < (64'd1 << top)) lsh++;
    for (int i = 0; i < 3; i++) begin
      s = (m[i] >> rsh) << lsh;
      v[i] = v[i][63] ? -$signed(s) : $signed(s);
    end
    return 1;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic normal_t face_normal(input logic signed [31:0] p[9]);
    logic signed [63:0] e1[3];
    logic signed [63:0] e2[3];
    logic signed [63:0] cr[3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    logic [15:0] comp[3];
    normal_t r;
    bit ok;
    r = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
    for (int i = 0; i < 3; i++) begin
      e1[i] = 64'(p[3+i]) - 64'(p[i]);
      e2[i] = 64'(p[6+i]) - 64'(p[i]);
    end
    ok = shift_to_top(e1, 30);
    ok = shift_to_top(e2, 30) && ok;
    if (!ok) return r;
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (!shift_to_top(cr, 29)) return r;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += abs64(cr[i]) * abs64(cr[i]);
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((abs64(cr[i]) << 14) + (len >> 1)) / len;
      comp[i] = cr[i][63] ? 16'(-q) : 16'(q);
    end
    r = '{nx: comp[0], ny: comp[1], nz: comp[2], degen: 1'b0};
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] pts[9];
    normal_t got;
    normal_t want;
    if (!rst_ni) begin
      fails = 0;
      normals_due.delete();
    end else begin
      if (tri_mon.valid && tri_mon.ready) begin
        pts = '{tri_mon.base_x, tri_mon.base_y, tri_mon.base_z,
                tri_mon.first_x, tri_mon.first_y, tri_mon.first_z,
                tri_mon.second_x, tri_mon.second_y, tri_mon.second_z};
        normals_due.push_back(face_normal(pts));
      end
      if (norm_mon.valid && norm_mon.ready) begin
        got = '{nx: norm_mon.normal_x, ny: norm_mon.normal_y, nz: norm_mon.normal_z,
                degen: norm_mon.degenerate};
        if (normals_due.size() == 0) begin
          $error("normal arrived with none outstanding");
          fails++;
        end else begin
          want = normals_due.pop_front();
          if (got.nx !== want.nx) begin
            $error("normal_x expected %0d actual %0d", $signed(want.nx), $signed(got.nx));
            fails++;
          end
          if (got.ny !== want.ny) begin
            $error("normal_y expected %0d actual %0d", $signed(want.ny), $signed(got.ny));
            fails++;
          end
          if (got.nz !== want.nz) begin
            $error("normal_z expected %0d actual %0d", $signed(want.nz), $signed(got.nz));
            fails++;
          end
          if (got.degen !== want.degen) begin
            $error("degenerate expected %0b actual %0b", want.degen, got.degen);
            fails++;
          end
        end
      end
    end
  end

endmodule

FILE: verif/triangle_face_normal_top_test.sv
// Testbench top: drives triangles into the face normal block and reports the verdict.
`timescale 1ns / 1ps
module triangle_face_normal_top_test;

  localparam int unsigned RandomItems = 930;
  localparam int unsigned QuietTail   = 150;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  bit sink_calm;
  bit hold_off;

  tfn_in_if  tri_ch ();
  tfn_out_if norm_ch ();

  triangle_face_normal_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tri_ch),
    .out_o (norm_ch)
  );

  tfn_normal_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_mon     (tri_ch),
    .norm_mon    (norm_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    tri_ch.valid = 1'b0;
    {tri_ch.base_x, tri_ch.base_y, tri_ch.base_z} = '0;
    {tri_ch.first_x, tri_ch.first_y, tri_ch.first_z} = '0;
    {tri_ch.second_x, tri_ch.second_y, tri_ch.second_z} = '0;
    norm_ch.ready = 1'b0;
    // A real falling edge on the reset, before the first clock edge.
    #0.25;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Result side: random stall bursts, one long hold-off, none near the end.
  initial begin
    int unsigned burst;
    sink_calm = 1'b0;
    hold_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        norm_ch.ready <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        norm_ch.ready <= 1'b0;
        repeat (burst) @(negedge clk_i);
      end
      norm_ch.ready <= 1'b1;
    end
  end

  task automatic offer_triangle(input logic [31:0] p[9], input bit may_idle);
    int unsigned gap;
    if (may_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      tri_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tri_ch.valid <= 1'b1;
    {tri_ch.base_x, tri_ch.base_y, tri_ch.base_z} <= {p[0], p[1], p[2]};
    {tri_ch.first_x, tri_ch.first_y, tri_ch.first_z} <= {p[3], p[4], p[5]};
    {tri_ch.second_x, tri_ch.second_y, tri_ch.second_z} <= {p[6], p[7], p[8]};
    @(posedge clk_i);
    while (!tri_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(input int unsigned style);
    case (style)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] p[9];
    logic [31:0] mn;
    logic [31:0] mx;
    int unsigned style;
    int unsigned k;
    @(posedge rst_ni);
    @(negedge clk_i);
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    // Directed: extremes, zero-length edges, parallel edges, axis triangles.
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                 offer_triangle(p, 0);
    p = '{1, 2, 3, 1, 2, 3, 5, 6, 7};                 offer_triangle(p, 0);
    p = '{1, 2, 3, 5, 6, 7, 1, 2, 3};                 offer_triangle(p, 0);
    p = '{0, 0, 0, 1, 2, 3, 2, 4, 6};                 offer_triangle(p, 0);
    p = '{0, 0, 0, 1, 1, 1, mn, mn, mn};              offer_triangle(p, 0);
    p = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0}; offer_triangle(p, 0);
    p = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0}; offer_triangle(p, 0);
    p = '{0, 0, 0, 0, 0, 1, 1, 0, 0};                 offer_triangle(p, 0);
    p = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};        offer_triangle(p, 0);
    p = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};        offer_triangle(p, 0);
    p = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};        offer_triangle(p, 0);
    p = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};        offer_triangle(p, 0);
    p = '{32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF};
    offer_triangle(p, 0);
    p = '{0, 0, 0, 1, 0, 0, 0, mx, 1};                offer_triangle(p, 0);
    p = '{0, 0, 0, mx, 1, 0, mx, 2, 0};               offer_triangle(p, 0);
    // Sender waits until every result is back.
    tri_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // Receiver holds off while triangles keep coming, filling the pipeline.
    hold_off = 1'b1;
    for (k = 0; k < RandomItems; k++) begin
      if (k == RandomItems - QuietTail) sink_calm = 1'b1;
      style = $urandom_range(0, 4);
      for (int i = 0; i < 9; i++) p[i] = pick_coord(style == 0 ? $urandom_range(0, 4) : style);
      // Occasionally force a zero-length or parallel edge with random content.
      case ($urandom_range(0, 9))
        0: begin p[3] = p[0]; p[4] = p[1]; p[5] = p[2]; end
        1: begin p[6] = p[3]; p[7] = p[4]; p[8] = p[5]; end
        default: ;
      endcase
      offer_triangle(p, k < RandomItems - QuietTail);
    end
    tri_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  always @(posedge clk_i) begin
    if ((tri_ch.valid && tri_ch.ready) || (norm_ch.valid && norm_ch.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tfn_pkg.sv
rtl/core/tfn_in_if.sv
rtl/core/tfn_out_if.sv
rtl/core/tfn_norm.sv
rtl/core/triangle_face_normal_top.sv
verif/tfn_normal_checker.sv
verif/triangle_face_normal_top_test.sv
